@@ sv/ttce_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and control/status structs of the text terminal cell engine
package ttce_pkg;

	localparam logic [1:0] CMD_PRINT  = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'd15;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic       use_cursor;
		logic [4:0] row;
		logic [6:0] col;
	} in_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} out_t;

	typedef enum logic [3:0] {
		ST_RST_SWEEP,
		ST_IDLE,
		ST_DECODE,
		ST_CLR_SWEEP,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_ZERO,
		ST_BS_WR,
		ST_BS_SCAN,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_SWEEP_START,
		OP_SWEEP,
		OP_READ,
		OP_NL,
		OP_CR,
		OP_GLYPH,
		OP_SCR_RD,
		OP_SCR_WR,
		OP_ZERO,
		OP_BS_START,
		OP_BS_WR,
		OP_BS_SCAN,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       is_nl;
		logic       is_cr;
		logic       is_bs;
		logic       idx_zero;
		logic       last_row;
		logic       last_cell;
		logic       cur_row_zero;
		logic       ptr_zero;
		logic       ptr_last;
		logic       ptr_next_lim;
		logic       ptr_next_zlim;
		logic       rd_char_zero;
	} stat_t;

endpackage

@@ sv/ttce_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine of the text terminal cell engine
module ttce_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ttce_pkg::stat_t stat,
	output ttce_pkg::ctrl_t ctrl,
	output logic           busy
);

	ttce_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttce_pkg::ST_RST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl.op = ttce_pkg::OP_NONE;
		busy    = 1'b1;
		case (state_q)
			ttce_pkg::ST_RST_SWEEP: begin
				ctrl.op = ttce_pkg::OP_SWEEP;
				if (stat.ptr_last) state_d = ttce_pkg::ST_IDLE;
			end
			ttce_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.op = ttce_pkg::OP_LATCH;
					state_d = ttce_pkg::ST_DECODE;
				end
			end
			ttce_pkg::ST_DECODE: begin
				state_d = ttce_pkg::ST_DONE;
				case (stat.cmd)
					ttce_pkg::CMD_READ: ctrl.op = ttce_pkg::OP_READ;
					ttce_pkg::CMD_CLEAR: begin
						ctrl.op = ttce_pkg::OP_SWEEP_START;
						state_d = ttce_pkg::ST_CLR_SWEEP;
					end
					ttce_pkg::CMD_PRINT: begin
						if (stat.is_nl) begin
							ctrl.op = ttce_pkg::OP_NL;
							if (stat.last_row)
								state_d = stat.cur_row_zero ? ttce_pkg::ST_ZERO
								                            : ttce_pkg::ST_SCR_RD;
						end else if (stat.is_cr) begin
							ctrl.op = ttce_pkg::OP_CR;
						end else if (stat.is_bs) begin
							if (!stat.idx_zero) begin
								ctrl.op = ttce_pkg::OP_BS_START;
								state_d = ttce_pkg::ST_BS_WR;
							end
						end else begin
							ctrl.op = ttce_pkg::OP_GLYPH;
							if (stat.last_cell)
								state_d = stat.cur_row_zero ? ttce_pkg::ST_ZERO
								                            : ttce_pkg::ST_SCR_RD;
						end
					end
					default: ctrl.op = ttce_pkg::OP_NONE;
				endcase
			end
			ttce_pkg::ST_CLR_SWEEP: begin
				ctrl.op = ttce_pkg::OP_SWEEP;
				if (stat.ptr_last) state_d = ttce_pkg::ST_DONE;
			end
			ttce_pkg::ST_SCR_RD: begin
				ctrl.op = ttce_pkg::OP_SCR_RD;
				state_d = ttce_pkg::ST_SCR_WR;
			end
			ttce_pkg::ST_SCR_WR: begin
				ctrl.op = ttce_pkg::OP_SCR_WR;
				state_d = stat.ptr_next_lim ? ttce_pkg::ST_ZERO : ttce_pkg::ST_SCR_RD;
			end
			ttce_pkg::ST_ZERO: begin
				ctrl.op = ttce_pkg::OP_ZERO;
				if (stat.ptr_next_zlim) state_d = ttce_pkg::ST_DONE;
			end
			ttce_pkg::ST_BS_WR: begin
				ctrl.op = ttce_pkg::OP_BS_WR;
				state_d = stat.ptr_zero ? ttce_pkg::ST_DONE : ttce_pkg::ST_BS_SCAN;
			end
			ttce_pkg::ST_BS_SCAN: begin
				ctrl.op = ttce_pkg::OP_BS_SCAN;
				if (!stat.rd_char_zero || stat.ptr_zero) state_d = ttce_pkg::ST_DONE;
			end
			ttce_pkg::ST_DONE: begin
				ctrl.op = ttce_pkg::OP_EMIT;
				state_d = ttce_pkg::ST_IDLE;
			end
			default: state_d = ttce_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ sv/ttce_dp.sv @@
`timescale 1ns / 1ps
// datapath of the text terminal cell engine: screen memory, cursor and scan pointers
module ttce_dp #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ttce_pkg::in_t   req,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  ttce_pkg::ctrl_t ctrl,
	output ttce_pkg::stat_t stat,
	output logic            done,
	output ttce_pkg::out_t  rsp
);

	localparam int CELLS = COLS * ROWS;
	localparam int IW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);

	logic [15:0] mem [CELLS];
	logic [15:0] rd_q;

	logic [7:0]    dflt_attr_q;
	logic [1:0]    cmd_q;
	logic [7:0]    ch_q;
	logic [7:0]    at_q;
	logic [RW-1:0] tgt_row_q, cur_row_q, prow_q;
	logic [CW-1:0] tgt_col_q, cur_col_q, pcol_q;
	logic [IW-1:0] tgt_idx_q, ptr_q, lim_q, zlim_q;
	logic          done_q;
	ttce_pkg::out_t rsp_q;

	logic [RW-1:0] in_row, sel_row, dec_row;
	logic [CW-1:0] in_col, sel_col, dec_col;
	logic          we, re;
	logic [IW-1:0] waddr, raddr;
	logic [15:0]   wdata;

	// clamp the requested cell into the screen
	assign in_row  = (32'(req.row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(req.row);
	assign in_col  = (32'(req.col) > COLS - 1) ? CW'(COLS - 1) : CW'(req.col);
	assign sel_row = (req.cmd == ttce_pkg::CMD_PRINT && req.use_cursor) ? cur_row_q : in_row;
	assign sel_col = (req.cmd == ttce_pkg::CMD_PRINT && req.use_cursor) ? cur_col_q : in_col;

	// scan pointer one cell back, as row and column
	assign dec_row = (pcol_q == '0) ? prow_q - RW'(1) : prow_q;
	assign dec_col = (pcol_q == '0) ? CW'(COLS - 1) : pcol_q - CW'(1);

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = ptr_q;
		wdata = 16'h0000;
		raddr = ptr_q;
		case (ctrl.op)
			ttce_pkg::OP_SWEEP: begin
				we    = 1'b1;
				wdata = (32'(ptr_q) < CELLS - COLS) ? {dflt_attr_q, ttce_pkg::CH_SPACE} : 16'h0000;
			end
			ttce_pkg::OP_READ: begin
				re    = 1'b1;
				raddr = tgt_idx_q;
			end
			ttce_pkg::OP_GLYPH: begin
				we    = 1'b1;
				waddr = tgt_idx_q;
				wdata = {at_q, ch_q};
			end
			ttce_pkg::OP_SCR_RD: begin
				re    = 1'b1;
				raddr = IW'(32'(ptr_q) + COLS);
			end
			ttce_pkg::OP_SCR_WR: begin
				we    = 1'b1;
				wdata = rd_q;
			end
			ttce_pkg::OP_ZERO: we = 1'b1;
			ttce_pkg::OP_BS_START: begin
				re    = 1'b1;
				raddr = tgt_idx_q - IW'(1);
			end
			ttce_pkg::OP_BS_WR: begin
				we    = 1'b1;
				wdata = {rd_q[15:8], 8'h00};
				re    = (ptr_q != '0);
				raddr = ptr_q - IW'(1);
			end
			ttce_pkg::OP_BS_SCAN: begin
				re    = (rd_q[7:0] == 8'h00) && (ptr_q != '0);
				raddr = ptr_q - IW'(1);
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == ttce_pkg::OP_LATCH) begin
			cmd_q     <= req.cmd;
			ch_q      <= req.char_code;
			at_q      <= (req.attribute == 8'h00) ? dflt_attr_q : req.attribute;
			tgt_row_q <= sel_row;
			tgt_col_q <= sel_col;
			tgt_idx_q <= IW'(32'(sel_row) * COLS + 32'(sel_col));
		end
		if (ctrl.op == ttce_pkg::OP_EMIT) begin
			rsp_q.cursor_pos <= 11'(32'(cur_row_q) * COLS + 32'(cur_col_q));
			rsp_q.cell_char  <= (cmd_q == ttce_pkg::CMD_READ) ? rd_q[7:0] : 8'h00;
			rsp_q.cell_attr  <= (cmd_q == ttce_pkg::CMD_READ) ? rd_q[15:8] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_attr_q <= ttce_pkg::ATTR_RESET;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			ptr_q       <= '0;
			prow_q      <= '0;
			pcol_q      <= '0;
			lim_q       <= '0;
			zlim_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (ctrl.op == ttce_pkg::OP_EMIT);
			if (cfg_we) dflt_attr_q <= cfg_wdata;
			case (ctrl.op)
				ttce_pkg::OP_SWEEP_START: begin
					ptr_q <= '0;
				end
				ttce_pkg::OP_SWEEP: begin
					ptr_q     <= (32'(ptr_q) == CELLS - 1) ? '0 : ptr_q + IW'(1);
					cur_row_q <= '0;
					cur_col_q <= '0;
				end
				ttce_pkg::OP_NL, ttce_pkg::OP_GLYPH: begin
					if ((ctrl.op == ttce_pkg::OP_NL && stat.last_row) ||
					    (ctrl.op == ttce_pkg::OP_GLYPH && stat.last_cell)) begin
						// scroll set-up around the row of the stored cursor
						ptr_q     <= '0;
						lim_q     <= IW'(32'(cur_row_q) * COLS);
						zlim_q    <= IW'(32'(cur_row_q) * COLS + COLS);
						cur_row_q <= RW'(ROWS - 1);
						cur_col_q <= '0;
					end else if (ctrl.op == ttce_pkg::OP_NL ||
					             32'(tgt_col_q) == COLS - 1) begin
						cur_row_q <= tgt_row_q + RW'(1);
						cur_col_q <= '0;
					end else begin
						cur_row_q <= tgt_row_q;
						cur_col_q <= tgt_col_q + CW'(1);
					end
				end
				ttce_pkg::OP_CR: begin
					cur_row_q <= tgt_row_q;
					cur_col_q <= '0;
				end
				ttce_pkg::OP_SCR_WR, ttce_pkg::OP_ZERO: begin
					ptr_q <= ptr_q + IW'(1);
				end
				ttce_pkg::OP_BS_START: begin
					ptr_q  <= tgt_idx_q - IW'(1);
					prow_q <= (tgt_col_q == '0) ? tgt_row_q - RW'(1) : tgt_row_q;
					pcol_q <= (tgt_col_q == '0) ? CW'(COLS - 1) : tgt_col_q - CW'(1);
				end
				ttce_pkg::OP_BS_WR: begin
					if (ptr_q == '0) begin
						cur_row_q <= '0;
						cur_col_q <= '0;
					end else begin
						ptr_q  <= ptr_q - IW'(1);
						prow_q <= dec_row;
						pcol_q <= dec_col;
					end
				end
				ttce_pkg::OP_BS_SCAN: begin
					if (rd_q[7:0] != 8'h00) begin
						// land just after the non-zero cell
						if (32'(pcol_q) == COLS - 1) begin
							cur_row_q <= prow_q + RW'(1);
							cur_col_q <= '0;
						end else begin
							cur_row_q <= prow_q;
							cur_col_q <= pcol_q + CW'(1);
						end
					end else if (ptr_q == '0) begin
						cur_row_q <= '0;
						cur_col_q <= '0;
					end else begin
						ptr_q  <= ptr_q - IW'(1);
						prow_q <= dec_row;
						pcol_q <= dec_col;
					end
				end
				default: ptr_q <= ptr_q;
			endcase
		end
	end

	assign stat.cmd           = cmd_q;
	assign stat.is_nl         = (ch_q == ttce_pkg::CH_NEWLINE);
	assign stat.is_cr         = (ch_q == ttce_pkg::CH_RETURN);
	assign stat.is_bs         = (ch_q == ttce_pkg::CH_BACKSPACE);
	assign stat.idx_zero      = (tgt_idx_q == '0);
	assign stat.last_row      = (32'(tgt_row_q) == ROWS - 1);
	assign stat.last_cell     = (32'(tgt_row_q) == ROWS - 1) && (32'(tgt_col_q) == COLS - 1);
	assign stat.cur_row_zero  = (cur_row_q == '0);
	assign stat.ptr_zero      = (ptr_q == '0);
	assign stat.ptr_last      = (32'(ptr_q) == CELLS - 1);
	assign stat.ptr_next_lim  = ((ptr_q + IW'(1)) == lim_q);
	assign stat.ptr_next_zlim = ((ptr_q + IW'(1)) == zlim_q);
	assign stat.rd_char_zero  = (rd_q[7:0] == 8'h00);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ sv/text_terminal_cell_engine_core.sv @@
`timescale 1ns / 1ps
// top level of the text terminal cell engine: controller plus datapath
//
// A COLS x ROWS character-cell screen (16-bit cells, attribute in the high byte)
// with a cursor. A command transaction is taken when start is high and busy is
// low; exactly one result follows on rsp, marked by done for a single cycle,
// and it must be captured then because the receiver cannot stall the block.
// Commands are handled one at a time by a sequencer driving one screen memory
// with one write and one registered read port. A scroll copies each cell of
// the rows moved up with a read and then a write, then zeroes the row left
// free; backspace at cell 0 does nothing, otherwise it zeroes the character
// of the cell before the target and scans back until a non-zero character or
// cell 0. Clear and the pass run after reset write blanks in the default
// attribute to every row but the last, which they zero; after reset this runs
// before the first command is taken (busy stays high meanwhile). The default
// attribute register may be written at any idle time.
module text_terminal_cell_engine_core #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	// command channel
	input  logic           start,
	output logic           busy,
	input  ttce_pkg::in_t  req,
	// result channel, one cycle strobe
	output logic           done,
	output ttce_pkg::out_t rsp,
	// default attribute register
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata
);

	ttce_pkg::ctrl_t ctrl;
	ttce_pkg::stat_t stat;

	// sequencer: one state per phase of a command
	ttce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// screen memory, cursor, scroll and backspace pointers
	ttce_dp #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctrl      (ctrl),
		.stat      (stat),
		.done      (done),
		.rsp       (rsp)
	);

endmodule
